/* rtl/core/chacha20_stream_cipher_defines.svh */
// Assertion macros used by the ChaCha20 stream cipher checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CC20_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cc20 same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CC20_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cc20 next-cycle check failed");

`endif

/* rtl/core/cc20_pkg.sv */
// Types, constants and round functions for the ChaCha20 stream cipher.
// No dependencies; imported by every module of the block but cc20_fifo.
`timescale 1ns / 1ps

package cc20_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;

    localparam logic [31:0] COUNTER_RESET = 32'd1;
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_01   = 3'd0,
        REG_KEY_23   = 3'd1,
        REG_KEY_45   = 3'd2,
        REG_KEY_67   = 3'd3,
        REG_NONCE_01 = 3'd4,
        REG_NONCE_2  = 3'd5,
        REG_INIT_CTR = 3'd6
    } reg_idx_e;

    typedef struct packed {
        logic [31:0] data_in;
        logic [2:0]  byte_count;
        logic        message_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [2:0]  out_byte_count;
    } out_item_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic [3:0]  pos;
        logic        gen;
        logic [31:0] counter;
    } job_t;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } cfg_t;

    typedef logic [15:0][31:0] state_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } qr_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic qr_t qround(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c, input logic [31:0] d);
        qr_t r;
        r.a = a + b;      r.d = rotl(d ^ r.a, 16);
        r.c = c + r.d;    r.b = rotl(b ^ r.c, 12);
        r.a = r.a + r.b;  r.d = rotl(r.d ^ r.a, 8);
        r.c = r.c + r.d;  r.b = rotl(r.b ^ r.c, 7);
        return r;
    endfunction

    function automatic state_t column_round(input state_t s);
        state_t o;
        qr_t q0, q1, q2, q3;
        q0 = qround(s[0], s[4], s[8],  s[12]);
        q1 = qround(s[1], s[5], s[9],  s[13]);
        q2 = qround(s[2], s[6], s[10], s[14]);
        q3 = qround(s[3], s[7], s[11], s[15]);
        o[0] = q0.a; o[4] = q0.b; o[8]  = q0.c; o[12] = q0.d;
        o[1] = q1.a; o[5] = q1.b; o[9]  = q1.c; o[13] = q1.d;
        o[2] = q2.a; o[6] = q2.b; o[10] = q2.c; o[14] = q2.d;
        o[3] = q3.a; o[7] = q3.b; o[11] = q3.c; o[15] = q3.d;
        return o;
    endfunction

    function automatic state_t diagonal_round(input state_t s);
        state_t o;
        qr_t q0, q1, q2, q3;
        q0 = qround(s[0], s[5], s[10], s[15]);
        q1 = qround(s[1], s[6], s[11], s[12]);
        q2 = qround(s[2], s[7], s[8],  s[13]);
        q3 = qround(s[3], s[4], s[9],  s[14]);
        o[0] = q0.a; o[5] = q0.b; o[10] = q0.c; o[15] = q0.d;
        o[1] = q1.a; o[6] = q1.b; o[11] = q1.c; o[12] = q1.d;
        o[2] = q2.a; o[7] = q2.b; o[8]  = q2.c; o[13] = q2.d;
        o[3] = q3.a; o[4] = q3.b; o[9]  = q3.c; o[14] = q3.d;
        return o;
    endfunction

    function automatic state_t init_state(input cfg_t cfg, input logic [31:0] counter);
        state_t s;
        s[0] = SIGMA_0;
        s[1] = SIGMA_1;
        s[2] = SIGMA_2;
        s[3] = SIGMA_3;
        for (int i = 0; i < 8; i++)
        begin
            s[4 + i] = cfg.key[i];
        end
        s[12] = counter;
        s[13] = cfg.nonce[0];
        s[14] = cfg.nonce[1];
        s[15] = cfg.nonce[2];
        return s;
    endfunction

    function automatic logic [2:0] sat_count(input logic [2:0] count);
        return (count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : count;
    endfunction

    // A byte lane is kept when its index is below the valid byte count.
    function automatic logic [31:0] byte_mask(input logic [2:0] count);
        logic [31:0] m;
        for (int i = 0; i < 4; i++)
        begin
            m[8*i +: 8] = (3'(i) < count) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

/* rtl/core/chacha20_stream_cipher.sv */
// Top level of the ChaCha20 stream cipher: configuration registers, front,
// job queue, back and result queue. Uses cc20_pkg, cc20_front, cc20_fifo, cc20_back.
//
//  Port group   Direction   Handshake          Payload
//  ----------   ---------   ----------------   -------------------------------
//  input        in          push / full        in_item (data_in, byte_count,
//                                              message_start)
//  result       out         empty / pop        out_item (data_out, out_byte_count)
//  config       in          cfg_wr_en          cfg_index, cfg_data
//
// A word inside a block is XORed with the buffered keystream in the back end.
// The first word of each block waits while the shared half-round unit
// generates its keystream block, doing one column or diagonal round per cycle.
// Reset clears control state only; the keystream buffer has no clearing pass.
// The front keeps accepting words while the back generates or the result queue
// is stalled, until the job queue fills.
`timescale 1ns / 1ps

module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_item_t               in_item,
    output logic                   empty,
    input  logic                   pop,
    output out_item_t              out_item,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic [31:0] init_ctr_reg;

    logic        job_push;
    logic        job_pop;
    logic        job_full;
    logic        job_empty;
    job_t        job_in;
    job_t        job_out;
    logic        res_push;
    logic        res_full;
    out_item_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            init_ctr_reg <= COUNTER_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_e'(cfg_index))
                REG_KEY_01:   cfg_reg.key[1:0]   <= cfg_data;
                REG_KEY_23:   cfg_reg.key[3:2]   <= cfg_data;
                REG_KEY_45:   cfg_reg.key[5:4]   <= cfg_data;
                REG_KEY_67:   cfg_reg.key[7:6]   <= cfg_data;
                REG_NONCE_01: cfg_reg.nonce[1:0] <= cfg_data;
                REG_NONCE_2:  cfg_reg.nonce[2]   <= cfg_data[31:0];
                REG_INIT_CTR: init_ctr_reg       <= cfg_data[31:0];
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign full = job_full;

    cc20_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .in_item      (in_item),
        .init_counter (init_ctr_reg),
        .job_full     (job_full),
        .job_push     (job_push),
        .job          (job_in)
    );

    cc20_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (job_full),
        .empty   (job_empty)
    );

    cc20_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    cc20_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .rd_en   (pop && !empty),
        .rd_data (out_item),
        .full    (res_full),
        .empty   (empty)
    );

endmodule

/* rtl/core/cc20_fifo.sv */
// Small register queue used between the front, the back and the result port.
// Depends on nothing; DEPTH must be a power of two of at least two.
`timescale 1ns / 1ps

module cc20_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;
    logic [AW:0]      cnt_next;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/cc20_front.sv */
// Front end: accepts data words, tracks word position and block counter,
// and marks the words that open a new keystream block. Uses cc20_pkg.
`timescale 1ns / 1ps

module cc20_front
    import cc20_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  in_item_t    in_item,
    input  logic [31:0] init_counter,
    input  logic        job_full,
    output logic        job_push,
    output job_t        job
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [31:0] ctr_reg;
    logic [31:0] ctr_next;
    logic [3:0]  pos_eff;
    logic [31:0] ctr_eff;

    assign job_push = push && !job_full;

    always_comb
    begin
        pos_eff = in_item.message_start ? 4'd0 : pos_reg;
        ctr_eff = in_item.message_start ? init_counter : ctr_reg;

        job.data    = in_item.data_in;
        job.count   = sat_count(in_item.byte_count);
        job.pos     = pos_eff;
        job.gen     = (pos_eff == 4'd0);
        job.counter = ctr_eff;

        pos_next = pos_eff + 4'd1;
        ctr_next = job.gen ? (ctr_eff + 32'd1) : ctr_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ctr_reg <= COUNTER_RESET;
        end
        else if (job_push)
        begin
            pos_reg <= pos_next;
            ctr_reg <= ctr_next;
        end
    end

endmodule

/* rtl/core/cc20_back.sv */
// Back end: generates keystream blocks with a shared half-round unit and
// XORs queued words with the buffered keystream. Uses cc20_pkg.
`timescale 1ns / 1ps

module cc20_back
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_empty,
    input  job_t      job,
    output logic      job_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);

    localparam int RW = $clog2(DOUBLE_ROUNDS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_FINAL = 3'b100
    } back_state_e;

    back_state_e state_reg, state_next;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic          diag_reg, diag_next;
    logic          gen_done_reg, gen_done_next;
    state_t        work_reg, work_next;
    state_t        init_reg, init_next;
    state_t        ks_reg, ks_next;

    always_comb
    begin
        res.data_out       = (job.data ^ ks_reg[job.pos]) & byte_mask(job.count);
        res.out_byte_count = job.count;
    end

    always_comb
    begin
        state_next    = state_reg;
        rnd_next      = rnd_reg;
        diag_next     = diag_reg;
        gen_done_next = gen_done_reg;
        work_next     = work_reg;
        init_next     = init_reg;
        ks_next       = ks_reg;
        job_pop       = 1'b0;
        res_push      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty && job.gen && !gen_done_reg)
                begin
                    init_next  = init_state(cfg, job.counter);
                    work_next  = init_next;
                    rnd_next   = '0;
                    diag_next  = 1'b0;
                    state_next = ST_ROUND;
                end
                else if (!job_empty && !res_full)
                begin
                    job_pop       = 1'b1;
                    res_push      = 1'b1;
                    gen_done_next = 1'b0;
                end
            end
            ST_ROUND:
            begin
                work_next = diag_reg ? diagonal_round(work_reg) : column_round(work_reg);
                diag_next = !diag_reg;
                if (diag_reg)
                begin
                    rnd_next = rnd_reg + 1'b1;
                    if (rnd_reg == RW'(DOUBLE_ROUNDS - 1))
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    ks_next[i] = work_reg[i] + init_reg[i];
                end
                gen_done_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rnd_reg      <= '0;
            diag_reg     <= 1'b0;
            gen_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rnd_reg      <= rnd_next;
            diag_reg     <= diag_next;
            gen_done_reg <= gen_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        init_reg <= init_next;
        ks_reg   <= ks_next;
    end

endmodule

/* rtl/core/cc20_checker.sv */
// Port-level checks for the ChaCha20 stream cipher, bound to its top level.
// Uses cc20_pkg and the macros of chacha20_stream_cipher_defines.svh.
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_defines.svh"

module cc20_checker
    import cc20_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    logic       in_xfer;
    logic       out_xfer;
    logic [7:0] pending_reg;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // Words accepted whose results have not been transferred yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pending_reg <= pending_reg + 8'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_reg <= pending_reg - 8'd1;
        end
    end

    `CC20_ASSERT_SAME(a_no_result_without_word, clk, rst_n,
        out_xfer, pending_reg != 8'd0)

    `CC20_ASSERT_SAME(a_count_in_range, clk, rst_n,
        !empty, out_item.out_byte_count <= FULL_WORD_BYTES)

    `CC20_ASSERT_SAME(a_short_word_top_byte_zero, clk, rst_n,
        !empty && out_item.out_byte_count != FULL_WORD_BYTES, out_item.data_out[31:24] == 8'h00)

    `CC20_ASSERT_NEXT(a_waiting_result_holds, clk, rst_n,
        !empty && !pop, !empty && $stable(out_item))

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);
